>>> hw/rtl/mfb_pkg.sv
// Package for the most frequent byte finder.
// Holds the fixed field widths and the stage control word; no dependencies.
`timescale 1ns / 1ps

package mfb_pkg;

    localparam int BYTE_W  = 8;   // data_byte and top_byte width
    localparam int COUNT_W = 8;   // top_count port width
    localparam int COUNT_SAT = 255;

    // Control carried with a byte through the read stage.
    typedef struct packed {
        logic valid;    // stage holds a word
        logic last;     // final byte of the string
        logic counted;  // byte is in the alphabet and within the length limit
        logic ovf;      // overflow seen so far in this string, this byte included
    } mfb_ctl_t;

endpackage

>>> hw/rtl/mfb_count_ram.sv
// Count / first-position store: one synchronous RAM plus per-entry valid bits.
// Does not depend on mfb_pkg (widths come in as parameters).
`timescale 1ns / 1ps

module mfb_count_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          clr,
    output logic [DW-1:0] rd_data,
    output logic          rd_hit
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_hit_reg;
    logic             fwd;

    // write in the same cycle as the read to the same entry: bypass
    assign fwd = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= fwd ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                // a clear on this edge empties the store for the new string
                rd_hit_reg <= !clr && (vld_reg[rd_addr] || fwd);
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

>>> hw/rtl/mfb_best_track.sv
// Modify stage: bumps the count read from the store and tracks the running best.
// Depends on mfb_pkg for the stage control word.
`timescale 1ns / 1ps

module mfb_best_track #(
    parameter int AW = 8,
    parameter int CW = 8,
    parameter int PW = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              proc,
    input  mfb_pkg::mfb_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  logic [PW-1:0]     pos,
    input  logic              rd_hit,
    input  logic [CW-1:0]     rd_cnt,
    input  logic [PW-1:0]     rd_fp,
    output logic              wr_en,
    output logic [CW-1:0]     wr_cnt,
    output logic [PW-1:0]     wr_fp,
    output logic [AW-1:0]     res_value,
    output logic [CW-1:0]     res_count
);

    import mfb_pkg::*;

    logic [AW-1:0] best_val_reg, best_val_next;
    logic [CW-1:0] best_cnt_reg, best_cnt_next;
    logic [PW-1:0] best_fp_reg,  best_fp_next;
    logic [CW-1:0] new_cnt;
    logic [PW-1:0] new_fp;
    logic          better;
    logic [AW-1:0] upd_val;
    logic [CW-1:0] upd_cnt;
    logic [PW-1:0] upd_fp;

    assign new_cnt = (rd_hit ? rd_cnt : '0) + CW'(1);
    assign new_fp  = rd_hit ? rd_fp : pos;
    assign better  = (new_cnt > best_cnt_reg) ||
                     ((new_cnt == best_cnt_reg) && (new_fp < best_fp_reg));

    assign wr_en  = proc && ctl.counted;
    assign wr_cnt = new_cnt;
    assign wr_fp  = new_fp;

    always_comb
    begin
        upd_val = best_val_reg;
        upd_cnt = best_cnt_reg;
        upd_fp  = best_fp_reg;
        if (wr_en && better)
        begin
            upd_val = addr;
            upd_cnt = new_cnt;
            upd_fp  = new_fp;
        end
        best_val_next = upd_val;
        best_cnt_next = upd_cnt;
        best_fp_next  = upd_fp;
        if (proc && ctl.last)
        begin
            best_val_next = '0;
            best_cnt_next = '0;
            best_fp_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_val_reg <= '0;
            best_cnt_reg <= '0;
            best_fp_reg  <= '0;
        end
        else
        begin
            best_val_reg <= best_val_next;
            best_cnt_reg <= best_cnt_next;
            best_fp_reg  <= best_fp_next;
        end
    end

    // final byte's own update counts toward the result
    assign res_value = upd_val;
    assign res_count = upd_cnt;

endmodule

>>> hw/rtl/most_frequent_byte_finder_unit.sv
// Most frequent byte finder: the result word is registered from the modify stage.
// 1 byte per cycle while byte_stall is low, set by the count RAM read-modify-write
// (write-to-read forwarding covers back-to-back bytes of the same value).
// Reset (rst_n, async) clears the valid bits of the store at once: no clearing pass.
// Each string's end clears the store, position and best.
// Depends on mfb_pkg, mfb_count_ram, mfb_best_track.
`timescale 1ns / 1ps

module most_frequent_byte_finder_unit #(
    parameter int MAX_LEN  = 128,
    parameter int ALPHABET = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [mfb_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [mfb_pkg::BYTE_W-1:0]  top_byte,
    output logic [mfb_pkg::COUNT_W-1:0] top_count,
    output logic                        overflow
);

    import mfb_pkg::*;

    // AW: store address, CW: count / position counter (holds MAX_LEN),
    // PW: first position (0 .. MAX_LEN-1), SW: width for the saturation compare
    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = (CW > COUNT_W) ? CW : COUNT_W + 1;

    // ---------------- accept stage: position, overflow, RAM read ----------------
    logic [CW-1:0] pos_reg, pos_next;
    logic          ovf_reg, ovf_next;
    logic          in_alpha;
    logic          room;
    logic          byte_accept;
    mfb_ctl_t      ctl_in;

    // read stage registers
    mfb_ctl_t      s1_ctl_reg, s1_ctl_next;
    logic [AW-1:0] s1_addr_reg;
    logic [PW-1:0] s1_pos_reg;

    logic          s1_blocked;
    logic          proc;
    logic          emit;

    assign in_alpha = ({1'b0, data_byte} < (BYTE_W + 1)'(ALPHABET));
    assign room     = (pos_reg < CW'(MAX_LEN));

    always_comb
    begin
        ctl_in.valid   = 1'b1;
        ctl_in.last    = last_byte;
        ctl_in.counted = in_alpha && room;
        ctl_in.ovf     = ovf_reg || (in_alpha && !room);
    end

    // read stage waits only when its final byte cannot hand its result over
    assign s1_blocked  = s1_ctl_reg.valid && s1_ctl_reg.last && result_valid && result_stall;
    assign byte_stall  = s1_blocked;
    assign byte_accept = byte_valid && !byte_stall;
    assign proc        = s1_ctl_reg.valid && !s1_blocked;
    assign emit        = proc && s1_ctl_reg.last;

    always_comb
    begin
        pos_next    = pos_reg;
        ovf_next    = ovf_reg;
        s1_ctl_next = s1_ctl_reg;
        if (proc)
        begin
            s1_ctl_next.valid = 1'b0;
        end
        if (byte_accept)
        begin
            s1_ctl_next = ctl_in;
            if (last_byte)
            begin
                // next word starts a new string
                pos_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + CW'(ctl_in.counted);
                ovf_next = ctl_in.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ovf_reg    <= 1'b0;
            s1_ctl_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            ovf_reg    <= ovf_next;
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_addr_reg <= data_byte[AW-1:0];
            s1_pos_reg  <= pos_reg[PW-1:0];
        end
    end

    // ---------------- count store ----------------
    logic [CW+PW-1:0] rd_word;
    logic             rd_hit;
    logic             wr_en;
    logic [CW-1:0]    wr_cnt;
    logic [PW-1:0]    wr_fp;

    mfb_count_ram #(
        .DEPTH (ALPHABET),
        .AW    (AW),
        .DW    (CW + PW)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (byte_accept),
        .rd_addr (data_byte[AW-1:0]),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data ({wr_cnt, wr_fp}),
        .clr     (emit),
        .rd_data (rd_word),
        .rd_hit  (rd_hit)
    );

    // ---------------- modify stage: count bump and running best ----------------
    logic [AW-1:0] res_value;
    logic [CW-1:0] res_count;

    mfb_best_track #(
        .AW (AW),
        .CW (CW),
        .PW (PW)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .ctl       (s1_ctl_reg),
        .addr      (s1_addr_reg),
        .pos       (s1_pos_reg),
        .rd_hit    (rd_hit),
        .rd_cnt    (rd_word[CW+PW-1:PW]),
        .rd_fp     (rd_word[PW-1:0]),
        .wr_en     (wr_en),
        .wr_cnt    (wr_cnt),
        .wr_fp     (wr_fp),
        .res_value (res_value),
        .res_count (res_count)
    );

    // ---------------- result register ----------------
    logic [SW-1:0]      cnt_ext;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  top_byte_reg;
    logic [COUNT_W-1:0] top_count_reg;
    logic               overflow_reg;

    // saturate counts above 255 (only reachable with long strings)
    assign cnt_ext = SW'(res_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            top_byte_reg  <= BYTE_W'(res_value);
            top_count_reg <= (cnt_ext > SW'(COUNT_SAT)) ? COUNT_W'(COUNT_SAT)
                                                        : cnt_ext[COUNT_W-1:0];
            overflow_reg  <= s1_ctl_reg.ovf;
        end
    end

    assign result_valid = out_valid_reg;
    assign top_byte     = top_byte_reg;
    assign top_count    = top_count_reg;
    assign overflow     = overflow_reg;

endmodule

>>> dv/mfb_mode_checker.sv
// Checker for the most frequent byte finder: watches both channels, predicts each
// result word and compares it field by field. Depends on mfb_pkg.
`timescale 1ns / 1ps

module mfb_mode_checker #(
    parameter int MAX_LEN  = 128,
    parameter int ALPHABET = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic                        byte_stall,
    input  logic [mfb_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic [mfb_pkg::BYTE_W-1:0]  top_byte,
    input  logic [mfb_pkg::COUNT_W-1:0] top_count,
    input  logic                        overflow,
    output int                          words_owed,
    output int                          mismatches
);

    import mfb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]  mode_byte;
        logic [COUNT_W-1:0] mode_count;
        logic               ovf;
    } mode_word_t;

    mode_word_t owed_q[$];

    // per-string histogram state
    int tally      [ALPHABET];
    int first_seen [ALPHABET];
    int taken;
    int lead_value;
    int lead_tally;
    int lead_first;
    bit too_long;
    int miss_total = 0;

    function void clear_string();
        foreach (tally[i]) tally[i] = 0;
        taken      = 0;
        lead_value = 0;
        lead_tally = 0;
        lead_first = 0;
        too_long   = 1'b0;
    endfunction

    function void tally_byte(input int v);
        int c;
        if (v >= ALPHABET) return;
        if (taken >= MAX_LEN)
        begin
            too_long = 1'b1;
            return;
        end
        if (tally[v] == 0) first_seen[v] = taken;
        c = tally[v] + 1;
        tally[v] = c;
        taken++;
        // higher count wins; equal count goes to the earlier first appearance
        if (c > lead_tally || (c == lead_tally && first_seen[v] < lead_first))
        begin
            lead_value = v;
            lead_tally = c;
            lead_first = first_seen[v];
        end
    endfunction

    function mode_word_t close_string();
        mode_word_t w;
        w.mode_byte  = BYTE_W'(lead_value);
        w.mode_count = COUNT_W'((lead_tally > COUNT_SAT) ? COUNT_SAT : lead_tally);
        w.ovf        = too_long;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mode_word_t want;
        if (!rst_n)
        begin
            owed_q.delete();
            clear_string();
            words_owed <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                tally_byte(int'(data_byte));
                if (last_byte)
                begin
                    owed_q.push_back(close_string());
                    clear_string();
                end
            end

            if (result_valid && !result_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    $error({"result word with none expected: ",
                            "top_byte %0d top_count %0d overflow %0d"},
                           top_byte, top_count, overflow);
                    miss_total++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (top_byte !== want.mode_byte)
                    begin
                        $error("top_byte: expected %0d, actual %0d", want.mode_byte, top_byte);
                        miss_total++;
                    end
                    if (top_count !== want.mode_count)
                    begin
                        $error("top_count: expected %0d, actual %0d", want.mode_count, top_count);
                        miss_total++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0d, actual %0d", want.ovf, overflow);
                        miss_total++;
                    end
                end
            end
            words_owed <= owed_q.size();
        end
        mismatches <= miss_total;
    end

endmodule

>>> dv/most_frequent_byte_finder_unit_test.sv
// Testbench top for most_frequent_byte_finder_unit: drives strings of bytes with bursty
// timing, stalls the result channel, and reports the verdict. Depends on mfb_pkg,
// mfb_mode_checker and the block itself.
`timescale 1ns / 1ps

module most_frequent_byte_finder_unit_test;
    import mfb_pkg::*;

    localparam int MAX_LEN      = 128;
    localparam int ALPHABET     = 256;
    localparam int CLK_PERIOD   = 10;
    localparam int ITEM_TARGET  = 1700;
    localparam int DRAIN_CYCLES = 6;          // leave a margin after the final drain
    localparam int RUN_LIMIT_NS = 3_000_000;  // several times the slowest clean run

    // Receiver behaviors on the result channel.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_mode_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               byte_valid   = 1'b0;
    logic               byte_stall;
    logic [BYTE_W-1:0]  data_byte    = '0;
    logic               last_byte    = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [BYTE_W-1:0]  top_byte;
    logic [COUNT_W-1:0] top_count;
    logic               overflow;

    int words_owed;
    int mismatches;

    // sender idling: a burst of words, then a gap bounded by sender_gap_max
    int burst_left     = 0;
    int sender_gap_max = 0;
    int items_sent     = 0;

    // byte values for the current string; a small palette forces repeats and ties
    logic [BYTE_W-1:0] palette [8];

    stall_mode_t stall_mode       = STALL_NONE;
    int          stall_phase_left = 0;
    int          stall_run        = 0;
    logic        stall_hold       = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    most_frequent_byte_finder_unit #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .top_byte     (top_byte),
        .top_count    (top_count),
        .overflow     (overflow)
    );

    mfb_mode_checker #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) mode_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .top_byte     (top_byte),
        .top_count    (top_count),
        .overflow     (overflow),
        .words_owed   (words_owed),
        .mismatches   (mismatches)
    );

    // Result-side stall: a random mode is picked for each phase of random length, so quiet
    // stretches, sparse stalls, heavy stalls and long stall runs all occur.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode       = stall_mode_t'($urandom_range(3, 0));
            stall_phase_left = $urandom_range(200, 20);
        end
        stall_phase_left--;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(3, 0) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(3, 0) != 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_hold = ~stall_hold;
                    stall_run  = $urandom_range(12, 1);
                end
                stall_run--;
                result_stall <= stall_hold;
            end
        endcase
    end

    // Offer one byte and hold it until the block takes it. byte_stall is read right
    // after the edge, i.e. the value that decided acceptance at that edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = (sender_gap_max == 0) ? 0 : $urandom_range(sender_gap_max, 0);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= fin;
        do
            @(posedge clk);
        while (byte_stall);
        items_sent++;
    endtask

    // Hold off the sender until every expected result word has come back.
    // words_owed is registered at the accepting edge, hence the first edge.
    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0) @(posedge clk);
    endtask

    // One string of len bytes; pal_size 0 means fully random bytes.
    task automatic send_string(input int len, input int pal_size);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < pal_size; i++) palette[i] = BYTE_W'($urandom_range(255, 0));
        for (int i = 0; i < len; i++)
        begin
            b = (pal_size == 0) ? BYTE_W'($urandom_range(255, 0))
                                : palette[$urandom_range(pal_size - 1, 0)];
            send_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        int n;
        int len;
        int pal_size;
        int pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings.
        sender_gap_max = 3;
        send_byte(8'h00, 1'b1);                         // single byte, lowest value
        send_byte(8'hFF, 1'b1);                         // single byte, highest value
        // two values tie on count: the one seen first wins
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        // a later value overtakes the early leader
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h02, 1'b1);
        // all distinct: first byte wins with count 1
        send_byte(8'h07, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // back-to-back repeats of one value exercise the counter forwarding
        repeat (4) send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // alternating pair, equal at the end
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        drain();

        // Random strings, mostly short; a few hit the length limit exactly or pass it.
        n = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(3, 0);
            sender_gap_max = (pick < 2) ? 0 : ((pick == 2) ? 3 : 10);
            pal_size = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (n == 3)
            begin
                len      = MAX_LEN;           // one value fills the string: top count
                pal_size = 1;
            end
            else if (n == 4)
                len = MAX_LEN + 1;            // one byte too many
            else if (n % 20 == 9)
                len = MAX_LEN + $urandom_range(30, 1);
            else
            begin
                pick = $urandom_range(99, 0);
                if (pick < 75)
                    len = $urandom_range(16, 1);
                else if (pick < 95)
                    len = $urandom_range(64, 17);
                else
                    len = $urandom_range(MAX_LEN, 65);
            end
            send_string(len, pal_size);
            n++;
            if (n % 40 == 0) drain();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("most_frequent_byte_finder_unit verification clean");
        else
            $display("most_frequent_byte_finder_unit verification failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("most_frequent_byte_finder_unit verification failed");
        $finish;
    end

endmodule

>>> most_frequent_byte_finder_unit.f
hw/rtl/mfb_pkg.sv
hw/rtl/mfb_count_ram.sv
hw/rtl/mfb_best_track.sv
hw/rtl/most_frequent_byte_finder_unit.sv
dv/mfb_mode_checker.sv
dv/most_frequent_byte_finder_unit_test.sv
